FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a consequent in the same cycle as its antecedent.
`define RDBB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define RDBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rdbb_pkg.sv
package rdbb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_LENGTH = 15;
    localparam int COL_W      = 11;
    localparam int SLOT_W     = 4;
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int MEM_DEPTH  = MAX_LENGTH * MAX_WIDTH;
    localparam int ACC_W      = 12;
    localparam int PEND_W     = 15;

    localparam logic [1:0] REG_WIDTH     = 2'd0;
    localparam logic [1:0] REG_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_LENGTH    = 2'd2;
    localparam logic [1:0] REG_DIRECTION = 2'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } res_req_t;

    typedef struct packed {
        logic clear;
        logic acc;
        logic step;
    } lane_ctrl_t;

    // Row number modulo the number of stored rows, using 16 = 1 (mod 15).
    function automatic logic [SLOT_W-1:0] row_slot(input logic [COL_W-1:0] row);
        logic [5:0] s1;
        logic [4:0] s2;
        s1 = 6'(row[3:0]) + 6'(row[7:4]) + 6'(row[10:8]);
        s2 = 5'(s1[3:0]) + 5'(s1[5:4]);
        if (s2 >= 5'(MAX_LENGTH))
        begin
            s2 = s2 - 5'(MAX_LENGTH);
        end
        return s2[SLOT_W-1:0];
    endfunction

endpackage

FILE: design/rdbb_lane.sv
module rdbb_lane (
    input  logic                  clk,
    input  rdbb_pkg::lane_ctrl_t  ctrl,
    input  logic [7:0]            sample,
    input  logic [3:0]            divisor,
    output logic [7:0]            quotient
);

    logic [rdbb_pkg::ACC_W-1:0] quo_reg;
    logic [3:0]                 rem_reg;
    logic [4:0]                 trial;
    logic                       fits;

    // The accumulator doubles as the dividend shift register.
    assign trial    = {rem_reg, quo_reg[rdbb_pkg::ACC_W-1]};
    assign fits     = trial >= {1'b0, divisor};
    assign quotient = quo_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            quo_reg <= quo_reg + rdbb_pkg::ACC_W'(sample);
        end
        else if (ctrl.step)
        begin
            rem_reg <= fits ? 4'(trial - {1'b0, divisor}) : trial[3:0];
            quo_reg <= {quo_reg[rdbb_pkg::ACC_W-2:0], fits};
        end
    end

endmodule

FILE: design/rdbb_merge.sv
module rdbb_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                no_taps,
    input  logic                frame_end,
    input  logic [7:0]          red_q,
    input  logic [7:0]          green_q,
    input  logic [7:0]          blue_q,
    input  logic                res_stall,
    output logic                res_valid,
    output rdbb_pkg::res_req_t  res_data,
    output logic                ready
);

    logic                valid_reg;
    rdbb_pkg::res_req_t  data_reg;

    assign ready     = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            data_reg.out_red   <= no_taps ? 8'd0 : red_q;
            data_reg.out_green <= no_taps ? 8'd0 : green_q;
            data_reg.out_blue  <= no_taps ? 8'd0 : blue_q;
            data_reg.frame_end <= frame_end;
        end
    end

endmodule

FILE: design/rgb_directional_box_blur.sv
// Channel  Direction  Handshake          Carries
// pix      in         valid / stall      opcode and one RGB pixel request
// res      out        valid / stall      one blurred RGB request and frame_end
// apb      in         psel / penable     frame size, blur length and direction
//
// A request that produces no result leaves the state at ST_IDLE, so the input is not stalled.
// A request that produces a result stalls the input until that result is loaded into the
// output register: one row store read per tap, then the ST_LAST state finishes the sums,
// then a 12-step divider runs per channel.
// The row store is not cleared after reset; reset clears positions and counts.
// A stalled result waits in the output register while the next request is taken.
module rgb_directional_box_blur (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  rdbb_pkg::pix_req_t  pix_data,
    output logic                res_valid,
    input  logic                res_stall,
    output rdbb_pkg::res_req_t  res_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TAP  = 5'b00010,
        ST_LAST = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] width_reg, height_reg;
    logic [3:0]  length_reg;
    logic        dir_reg;

    logic [rdbb_pkg::COL_W-1:0]  in_col_reg, in_row_reg, out_col_reg, out_row_reg;
    logic [rdbb_pkg::COL_W-1:0]  ctr_col_reg, ctr_row_reg;
    logic [rdbb_pkg::PEND_W-1:0] pending_reg;
    logic [3:0]                  tap_k_reg, div_cnt_reg, n_cnt_reg;
    logic                        tap_ok_reg, fend_reg;
    logic [23:0]                 rd_data_reg;
    logic [23:0]                 mem [0:rdbb_pkg::MEM_DEPTH-1];

    logic [11:0] eff_w, eff_h;
    logic [2:0]  half;
    logic [3:0]  span;
    logic [rdbb_pkg::PEND_W-1:0] lag;
    logic        accept, cfg_write, is_pixel, do_emit, mrg_ready, mrg_load;
    logic [12:0] coord;
    logic        tap_in;
    logic [rdbb_pkg::COL_W-1:0]  tap_row, tap_col;
    rdbb_pkg::lane_ctrl_t        lane_ctrl;
    logic [7:0]  red_q, green_q, blue_q;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pix_stall = state_reg != ST_IDLE;
    assign accept    = pix_valid && !pix_stall;
    assign is_pixel  = pix_data.opcode == rdbb_pkg::OP_PIXEL;

    always_comb
    begin
        eff_w = width_reg;
        if (width_reg == 12'd0)
        begin
            eff_w = 12'd1;
        end
        else if (width_reg > 12'(rdbb_pkg::MAX_WIDTH))
        begin
            eff_w = 12'(rdbb_pkg::MAX_WIDTH);
        end
        eff_h = height_reg;
        if (height_reg == 12'd0)
        begin
            eff_h = 12'd1;
        end
        else if (height_reg > 12'(rdbb_pkg::MAX_HEIGHT))
        begin
            eff_h = 12'(rdbb_pkg::MAX_HEIGHT);
        end
    end

    assign half = length_reg[3:1];
    assign span = {half, 1'b0};
    assign lag  = dir_reg ? rdbb_pkg::PEND_W'(half) * rdbb_pkg::PEND_W'(eff_w)
                          : rdbb_pkg::PEND_W'(half);

    always_comb
    begin
        if (is_pixel)
        begin
            do_emit = (16'(pending_reg) + 16'd1) > 16'(lag);
        end
        else
        begin
            do_emit = pending_reg != '0;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rdbb_pkg::REG_WIDTH:     prdata = 32'(width_reg);
            rdbb_pkg::REG_HEIGHT:    prdata = 32'(height_reg);
            rdbb_pkg::REG_LENGTH:    prdata = 32'(length_reg);
            rdbb_pkg::REG_DIRECTION: prdata = 32'(dir_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            length_reg <= 4'd5;
            dir_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                rdbb_pkg::REG_WIDTH:     width_reg  <= pwdata[11:0];
                rdbb_pkg::REG_HEIGHT:    height_reg <= pwdata[11:0];
                rdbb_pkg::REG_LENGTH:    length_reg <= pwdata[3:0];
                rdbb_pkg::REG_DIRECTION: dir_reg    <= pwdata[0];
                default:                 dir_reg    <= dir_reg;
            endcase
        end
    end

    always_comb
    begin
        if (dir_reg)
        begin
            coord   = 13'(ctr_row_reg) - 13'(half) + 13'(tap_k_reg);
            tap_in  = !coord[12] && (coord[11:0] < eff_h);
            tap_row = coord[10:0];
            tap_col = ctr_col_reg;
        end
        else
        begin
            coord   = 13'(ctr_col_reg) - 13'(half) + 13'(tap_k_reg);
            tap_in  = !coord[12] && (coord[11:0] < eff_w);
            tap_row = ctr_row_reg;
            tap_col = coord[10:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_pixel)
        begin
            mem[{rdbb_pkg::row_slot(in_row_reg), in_col_reg}] <=
                {pix_data.in_red, pix_data.in_green, pix_data.in_blue};
        end
        rd_data_reg <= mem[{rdbb_pkg::row_slot(tap_row), tap_col}];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && do_emit)
                begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                if (tap_k_reg == span)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 4'(rdbb_pkg::ACC_W - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (mrg_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mrg_load       = state_reg == ST_HOLD;
    assign lane_ctrl.clear = accept;
    assign lane_ctrl.acc   = tap_ok_reg;
    assign lane_ctrl.step  = state_reg == ST_DIV;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            tap_k_reg   <= '0;
            div_cnt_reg <= '0;
            n_cnt_reg   <= '0;
            tap_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tap_ok_reg <= (state_reg == ST_TAP) && tap_in;
            if (tap_ok_reg)
            begin
                n_cnt_reg <= n_cnt_reg + 4'd1;
            end
            if (state_reg == ST_TAP)
            begin
                tap_k_reg <= tap_k_reg + 4'd1;
            end
            if (state_reg == ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            if (accept)
            begin
                tap_k_reg   <= '0;
                div_cnt_reg <= '0;
                n_cnt_reg   <= '0;
                if (is_pixel)
                begin
                    if (12'(in_col_reg) + 12'd1 >= eff_w)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= (12'(in_row_reg) + 12'd1 >= eff_h) ? '0
                                      : in_row_reg + 11'd1;
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + 11'd1;
                    end
                end
                if (is_pixel && !do_emit)
                begin
                    pending_reg <= pending_reg + 15'd1;
                end
                else if (!is_pixel && do_emit)
                begin
                    pending_reg <= pending_reg - 15'd1;
                end
                if (do_emit)
                begin
                    if (12'(out_col_reg) + 12'd1 >= eff_w)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= (12'(out_row_reg) + 12'd1 >= eff_h) ? '0
                                       : out_row_reg + 11'd1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 11'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_emit)
        begin
            ctr_col_reg <= out_col_reg;
            ctr_row_reg <= out_row_reg;
            fend_reg    <= (12'(out_row_reg) == eff_h - 12'd1) &&
                           (12'(out_col_reg) == eff_w - 12'd1);
        end
    end

    rdbb_lane u_red (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .sample   (rd_data_reg[23:16]),
        .divisor  (n_cnt_reg),
        .quotient (red_q)
    );

    rdbb_lane u_green (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .sample   (rd_data_reg[15:8]),
        .divisor  (n_cnt_reg),
        .quotient (green_q)
    );

    rdbb_lane u_blue (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .sample   (rd_data_reg[7:0]),
        .divisor  (n_cnt_reg),
        .quotient (blue_q)
    );

    rdbb_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (mrg_load),
        .no_taps   (n_cnt_reg == 4'd0),
        .frame_end (fend_reg),
        .red_q     (red_q),
        .green_q   (green_q),
        .blue_q    (blue_q),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_data  (res_data),
        .ready     (mrg_ready)
    );

    `RDBB_ASSERT_SAME(a_tap_range, state_reg == ST_TAP, tap_k_reg <= span,
        "tap index beyond window")
    `RDBB_ASSERT_SAME(a_count_range, state_reg == ST_DIV, n_cnt_reg <= span + 4'd1,
        "tap count beyond window")
    `RDBB_ASSERT_NEXT(a_pixel_pending, accept && is_pixel && !do_emit,
        pending_reg != '0, "pixel taken without pending count")
    `RDBB_ASSERT_NEXT(a_result_shown, state_reg == ST_HOLD && mrg_ready,
        res_valid && state_reg == ST_IDLE, "result not presented")

endmodule

FILE: tb/sv/rdbb_checker.sv
module rdbb_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    input  logic                pix_stall,
    input  rdbb_pkg::pix_req_t  pix_data,
    input  logic                res_valid,
    input  logic                res_stall,
    input  rdbb_pkg::res_req_t  res_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  fails,
    output int                  outstanding
);
    import rdbb_pkg::*;

    logic [23:0] pixel_mem [0:MEM_DEPTH-1];
    res_req_t    blurred_q [$];
    int          cfg_width;
    int          cfg_height;
    int          cfg_length;
    int          cfg_direction;
    int          wr_row;
    int          wr_col;
    int          rd_row;
    int          rd_col;
    int          backlog;

    function automatic int frame_w();
        if (cfg_width == 0)
        begin
            return 1;
        end
        return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    endfunction

    function automatic int frame_h();
        if (cfg_height == 0)
        begin
            return 1;
        end
        return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
    endfunction

    function automatic int half_len();
        int h;
        h = cfg_length / 2;
        return (h > (MAX_LENGTH - 1) / 2) ? (MAX_LENGTH - 1) / 2 : h;
    endfunction

    function automatic res_req_t blur_next();
        int w;
        int hg;
        int h;
        int k;
        int x;
        int y;
        int n;
        int sr;
        int sg;
        int sb;
        logic [23:0] p;
        res_req_t o;
        w = frame_w();
        hg = frame_h();
        h = half_len();
        n = 0;
        sr = 0;
        sg = 0;
        sb = 0;
        for (k = -h; k <= h; k++)
        begin
            y = rd_row;
            x = rd_col;
            if (cfg_direction != 0)
            begin
                y = rd_row + k;
            end
            else
            begin
                x = rd_col + k;
            end
            if (y >= 0 && y < hg && x >= 0 && x < w)
            begin
                p = pixel_mem[(y % MAX_LENGTH) * MAX_WIDTH + x];
                sr += p[23:16];
                sg += p[15:8];
                sb += p[7:0];
                n++;
            end
        end
        o.out_red   = (n == 0) ? 8'd0 : 8'(sr / n);
        o.out_green = (n == 0) ? 8'd0 : 8'(sg / n);
        o.out_blue  = (n == 0) ? 8'd0 : 8'(sb / n);
        o.frame_end = (rd_row == hg - 1 && rd_col == w - 1);
        if (rd_col + 1 >= w)
        begin
            rd_col = 0;
            rd_row = (rd_row + 1 >= hg) ? 0 : rd_row + 1;
        end
        else
        begin
            rd_col++;
        end
        if (backlog > 0)
        begin
            backlog--;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_req_t exp_res;
        int w;
        int hg;
        int lag;
        int errs;
        if (!rst_n)
        begin
            blurred_q.delete();
            cfg_width <= 640;
            cfg_height <= 480;
            cfg_length <= 5;
            cfg_direction <= 0;
            wr_row = 0;
            wr_col = 0;
            rd_row = 0;
            rd_col = 0;
            backlog = 0;
            fails <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_WIDTH:     cfg_width <= int'(pwdata[11:0]);
                    REG_HEIGHT:    cfg_height <= int'(pwdata[11:0]);
                    REG_LENGTH:    cfg_length <= int'(pwdata[3:0]);
                    REG_DIRECTION: cfg_direction <= int'(pwdata[0]);
                    default: ;
                endcase
            end
            if (res_valid && !res_stall)
            begin
                if (blurred_q.size() == 0)
                begin
                    $error("result arrived with no request waiting for it");
                    errs++;
                end
                else
                begin
                    exp_res = blurred_q.pop_front();
                    if (res_data.out_red !== exp_res.out_red)
                    begin
                        $error("out_red expected %0d got %0d", exp_res.out_red,
                            res_data.out_red);
                        errs++;
                    end
                    if (res_data.out_green !== exp_res.out_green)
                    begin
                        $error("out_green expected %0d got %0d", exp_res.out_green,
                            res_data.out_green);
                        errs++;
                    end
                    if (res_data.out_blue !== exp_res.out_blue)
                    begin
                        $error("out_blue expected %0d got %0d", exp_res.out_blue,
                            res_data.out_blue);
                        errs++;
                    end
                    if (res_data.frame_end !== exp_res.frame_end)
                    begin
                        $error("frame_end expected %0d got %0d", exp_res.frame_end,
                            res_data.frame_end);
                        errs++;
                    end
                end
            end
            if (pix_valid && !pix_stall)
            begin
                w = frame_w();
                hg = frame_h();
                if (pix_data.opcode == OP_DRAIN)
                begin
                    if (backlog > 0)
                    begin
                        blurred_q.push_back(blur_next());
                    end
                end
                else
                begin
                    pixel_mem[(wr_row % MAX_LENGTH) * MAX_WIDTH + wr_col] =
                        {pix_data.in_red, pix_data.in_green, pix_data.in_blue};
                    if (wr_col + 1 >= w)
                    begin
                        wr_col = 0;
                        wr_row = (wr_row + 1 >= hg) ? 0 : wr_row + 1;
                    end
                    else
                    begin
                        wr_col++;
                    end
                    backlog++;
                    lag = (cfg_direction != 0) ? half_len() * w : half_len();
                    if (backlog > lag)
                    begin
                        blurred_q.push_back(blur_next());
                    end
                end
            end
            fails <= fails + errs;
            outstanding <= blurred_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_rgb_directional_box_blur.sv
module tb_rgb_directional_box_blur;
    import rdbb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_stall;
    pix_req_t    pix_data;
    logic        res_valid;
    logic        res_stall;
    res_req_t    res_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fails;
    int          outstanding;
    int          burst_left;
    int          stall_mode;
    int          stall_count;
    int          pixels_sent;
    int          drains_sent;
    int          settings_run;
    int          random_items;

    rgb_directional_box_blur dut (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_data(pix_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data(res_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    rdbb_checker blur_check (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_data(pix_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data(res_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .fails(fails),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    // The receiver switches between no stalls, light random stalls and heavy random stalls.
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_count <= $urandom_range(20, 200);
            res_stall <= 1'b0;
        end
        else
        begin
            stall_count <= stall_count - 1;
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                default: res_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_request(input logic op);
        logic stalled;
        if (burst_left == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 15);
        end
        burst_left--;
        pix_valid <= 1'b1;
        pix_data.opcode <= op;
        pix_data.in_red <= pick_channel();
        pix_data.in_green <= pick_channel();
        pix_data.in_blue <= pick_channel();
        forever
        begin
            @(negedge clk);
            stalled = pix_stall;
            @(posedge clk);
            if (!stalled)
            begin
                break;
            end
        end
        if (op == OP_DRAIN)
        begin
            drains_sent++;
        end
        else
        begin
            pixels_sent++;
        end
    endtask

    task automatic wait_idle();
        int guard;
        pix_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (outstanding != 0 && guard < 200000);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_setting(input int w, input int hg, input int len, input int dir,
                               input int frames);
        int ew;
        int eh;
        int lag;
        int total;
        int f;
        wait_idle();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, hg);
        reg_write(REG_LENGTH, len);
        reg_write(REG_DIRECTION, dir);
        settings_run++;
        ew = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
        eh = (hg == 0) ? 1 : ((hg > 2048) ? 2048 : hg);
        lag = (dir != 0) ? (len / 2) * ew : len / 2;
        total = ew * eh;
        for (f = 0; f < frames; f++)
        begin
            repeat ($urandom_range(0, 1)) send_request(OP_DRAIN);
            repeat (total) send_request(OP_PIXEL);
            repeat ((lag < total) ? lag : total) send_request(OP_DRAIN);
        end
    endtask

    initial
    begin
        int before_count;
        rst_n = 1'b0;
        pix_valid <= 1'b0;
        pix_data <= '0;
        res_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        stall_count = 0;
        stall_mode = 0;
        burst_left = 0;
        pixels_sent = 0;
        drains_sent = 0;
        settings_run = 0;
        random_items = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_setting(4, 3, 0, 0, 1);
        run_setting(5, 3, 2, 0, 1);
        run_setting(3, 5, 4, 1, 1);
        run_setting(6, 2, 15, 0, 1);
        run_setting(2, 9, 15, 1, 1);
        run_setting(1, 1, 7, 0, 2);
        run_setting(0, 0, 3, 1, 1);
        run_setting(7, 2, 1, 1, 1);

        while (random_items < 300)
        begin
            before_count = pixels_sent + drains_sent;
            run_setting($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 15),
                $urandom_range(0, 1), $urandom_range(1, 2));
            random_items += pixels_sent + drains_sent - before_count;
        end

        wait_idle();
        $display("Sent %0d pixels and %0d drain requests over %0d register settings.",
            pixels_sent, drains_sent, settings_run);
        $display("Frames ranged from single pixels to small strips in both blur directions.");
        if (fails == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
